### rtl/core/assert_macros.svh
// Assertion macros for the RTL: implication checks in the same and the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the cycle where ante holds.
`define CTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the cycle after ante holds.
`define CTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTP_ASSERT_IMP(lbl, ante, cons, msg)
`define CTP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/ctp_pkg.sv
// Package: constants, types and the arctangent table of the cartesian-to-polar converter.
`default_nettype none
package ctp_pkg;

  localparam int ITERATIONS = 16;
  localparam int ATAN_LEN   = 24;
  localparam int NUM_ROT    = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;
  localparam int SQRT_STEPS = 16;
  localparam int LOOP_STG   = (SQRT_STEPS > NUM_ROT) ? SQRT_STEPS : NUM_ROT;
  localparam int NUM_STG    = LOOP_STG + 3;

  localparam int COORD_W = 16;
  localparam int SQ_W    = 32;
  localparam int ROOT_W  = 16;
  localparam int TRIAL_W = SQ_W + 1;
  localparam int CW      = 35;
  localparam int ZW      = 27;
  localparam int Z_SH    = 11;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [15:0]        mag_t;
  typedef logic signed [15:0]        angle_t;
  typedef logic signed [CW-1:0]      cw_t;
  typedef logic signed [ZW-1:0]      zacc_t;

  localparam angle_t PI_Q13      = 16'sd25736;
  localparam angle_t HALF_PI_Q13 = 16'sd12868;
  localparam mag_t   MAG_MAX     = 16'd46341;
  localparam zacc_t  HALF_PI_Z   = 27'sd26353589;
  localparam zacc_t  Z_RND       = 27'sd1024;

  typedef enum logic [2:0] {
    SPEC_NONE,
    SPEC_ZERO,
    SPEC_POS_Y,
    SPEC_NEG_Y,
    SPEC_NEG_X
  } spec_t;

  // First stage: squares and the vector turned into the right half plane.
  typedef struct packed {
    logic [SQ_W-2:0] xx;
    logic [SQ_W-2:0] yy;
    cw_t             cx;
    cw_t             cy;
    zacc_t           z;
    spec_t           spec;
  } s0_t;

  // Later stages: square-root remainder and root next to the rotation state.
  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    cw_t               cx;
    cw_t               cy;
    zacc_t             z;
    spec_t             spec;
  } pipe_t;

  // round(atan(2^-i) * 2^24)
  function automatic zacc_t atan_lut(input logic [4:0] idx);
    zacc_t v;
    case (idx)
      5'd0:    v = 27'sd13176795;
      5'd1:    v = 27'sd7778716;
      5'd2:    v = 27'sd4110060;
      5'd3:    v = 27'sd2086331;
      5'd4:    v = 27'sd1047214;
      5'd5:    v = 27'sd524117;
      5'd6:    v = 27'sd262123;
      5'd7:    v = 27'sd131069;
      5'd8:    v = 27'sd65536;
      5'd9:    v = 27'sd32768;
      5'd10:   v = 27'sd16384;
      5'd11:   v = 27'sd8192;
      5'd12:   v = 27'sd4096;
      5'd13:   v = 27'sd2048;
      5'd14:   v = 27'sd1024;
      5'd15:   v = 27'sd512;
      5'd16:   v = 27'sd256;
      5'd17:   v = 27'sd128;
      5'd18:   v = 27'sd64;
      5'd19:   v = 27'sd32;
      5'd20:   v = 27'sd16;
      5'd21:   v = 27'sd8;
      5'd22:   v = 27'sd4;
      5'd23:   v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ctp_in_if.sv
// Input channel: one cartesian vector per transfer.
`default_nettype none
interface ctp_in_if;
  import ctp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface
`default_nettype wire

### rtl/core/ctp_out_if.sv
// Result channel: length and angle of one vector per transfer.
`default_nettype none
interface ctp_out_if;
  import ctp_pkg::*;

  logic   valid;
  logic   ready;
  mag_t   magnitude;
  angle_t angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface
`default_nettype wire

### rtl/core/cartesian_to_polar.sv
// Top level: pipelined cartesian-to-polar converter (square root and CORDIC vectoring).
//
//   channel  dir  payload                                  handshake
//   in_ch    in   x_coord, y_coord  (signed Q1.15)         valid / ready
//   out_ch   out  magnitude (unsigned), angle (Q3.13 rad)  valid / ready
//
// One transfer per cycle in and out while the output is taken; NUM_STG register
// stages (19 at 16 rotations). Depth is set by the longer of the 16
// square-root digit steps and the CORDIC rotations.
// Reset (synchronous, active low) clears only the stage valid bits and holds
// the input off.
// A stage takes new data whenever some stage at or after it is empty or the
// output is taken, so bubbles fill up and a stall drops or repeats nothing.
`default_nettype none
`include "assert_macros.svh"
module cartesian_to_polar (
  input  logic       clk,
  input  logic       rst_n,
  ctp_in_if.sink     in_ch,
  ctp_out_if.source  out_ch
);
  import ctp_pkg::*;

  // Flow control: one valid bit per stage, enable when a slot at or after it is free.
  logic [NUM_STG-1:0] v_r;
  logic [NUM_STG-1:0] vn;
  logic [NUM_STG-1:0] vin;
  logic [NUM_STG-1:0] en;
  logic               in_xfer;
  logic               out_xfer;

  assign vn  = ~v_r;
  assign vin = {v_r[NUM_STG-2:0], in_ch.valid};

  for (genvar k = 0; k < NUM_STG; k++) begin : g_en
    assign en[k] = out_ch.ready || (|(vn >> k));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en & vin) | (~en & v_r);
    end
  end

  // Hold the input off during reset so no transfer is dropped.
  assign in_ch.ready  = en[0] && rst_n;
  assign out_ch.valid = v_r[NUM_STG-1];
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = out_ch.valid && out_ch.ready;

  // Stage 0: classify the special axes, square both coordinates and turn a
  // left-half-plane vector by a quarter turn, seeding the angle with +/-pi/2.
  s0_t                 s0_nxt;
  s0_t                 s0_r;
  logic signed [31:0]  xsq;
  logic signed [31:0]  ysq;
  logic signed [16:0]  xe;
  logic signed [16:0]  ye;
  logic signed [16:0]  cx17;
  logic signed [16:0]  cy17;

  always_comb begin
    xe  = {in_ch.x_coord[COORD_W-1], in_ch.x_coord};
    ye  = {in_ch.y_coord[COORD_W-1], in_ch.y_coord};
    xsq = SQ_W'(in_ch.x_coord) * SQ_W'(in_ch.x_coord);
    ysq = SQ_W'(in_ch.y_coord) * SQ_W'(in_ch.y_coord);

    s0_nxt.xx = xsq[SQ_W-2:0];
    s0_nxt.yy = ysq[SQ_W-2:0];

    if (in_ch.x_coord == '0) begin
      if (in_ch.y_coord > 0) begin
        s0_nxt.spec = SPEC_POS_Y;
      end else if (in_ch.y_coord == '0) begin
        s0_nxt.spec = SPEC_ZERO;
      end else begin
        s0_nxt.spec = SPEC_NEG_Y;
      end
    end else if (in_ch.y_coord == '0) begin
      s0_nxt.spec = (in_ch.x_coord > 0) ? SPEC_ZERO : SPEC_NEG_X;
    end else begin
      s0_nxt.spec = SPEC_NONE;
    end

    if (in_ch.x_coord < 0) begin
      if (in_ch.y_coord > 0) begin
        cx17     = ye;
        cy17     = -xe;
        s0_nxt.z = HALF_PI_Z;
      end else begin
        cx17     = -ye;
        cy17     = xe;
        s0_nxt.z = -HALF_PI_Z;
      end
    end else begin
      cx17     = xe;
      cy17     = ye;
      s0_nxt.z = '0;
    end

    // scale by 2^16 into the working width
    s0_nxt.cx = {{(CW-33){cx17[16]}}, cx17, 16'b0};
    s0_nxt.cy = {{(CW-33){cy17[16]}}, cy17, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
  end

  // Stage 1: sum of squares, clear the root.
  pipe_t pipe_r [1:LOOP_STG+1];
  pipe_t p1_nxt;

  always_comb begin
    p1_nxt.rem  = {1'b0, s0_r.xx} + {1'b0, s0_r.yy};
    p1_nxt.root = '0;
    p1_nxt.cx   = s0_r.cx;
    p1_nxt.cy   = s0_r.cy;
    p1_nxt.z    = s0_r.z;
    p1_nxt.spec = s0_r.spec;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pipe_r[1] <= p1_nxt;
    end
  end

  // Stages 2..LOOP_STG+1: one root digit and one micro-rotation per stage.
  for (genvar j = 0; j < LOOP_STG; j++) begin : g_loop
    localparam int B = (j < SQRT_STEPS) ? (SQRT_STEPS - 1 - j) : 0;
    pipe_t               p;
    pipe_t               stg_nxt;
    logic [TRIAL_W-1:0]  trial;

    assign p = pipe_r[j+1];

    always_comb begin
      stg_nxt = p;
      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
      trial = (TRIAL_W'(p.root) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
      if ((j < SQRT_STEPS) && (TRIAL_W'(p.rem) >= trial)) begin
        stg_nxt.rem  = p.rem - trial[SQ_W-1:0];
        stg_nxt.root = p.root | (ROOT_W'(1) << B);
      end
      if (j < NUM_ROT) begin
        if (!p.cy[CW-1]) begin
          stg_nxt.cx = p.cx + (p.cy >>> j);
          stg_nxt.cy = p.cy - (p.cx >>> j);
          stg_nxt.z  = p.z + atan_lut(5'(j));
        end else begin
          stg_nxt.cx = p.cx - (p.cy >>> j);
          stg_nxt.cy = p.cy + (p.cx >>> j);
          stg_nxt.z  = p.z - atan_lut(5'(j));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        pipe_r[j+2] <= stg_nxt;
      end
    end
  end

  // Last stage: round the root, round and clamp the angle, apply the axes.
  pipe_t  pf;
  logic   rnd_up;
  zacc_t  zsum;
  zacc_t  zsh;
  angle_t ang_cordic;
  angle_t out_ang_nxt;
  mag_t   out_mag_nxt;
  mag_t   out_mag_r;
  angle_t out_ang_r;

  assign pf = pipe_r[LOOP_STG+1];

  always_comb begin
    rnd_up      = pf.rem > SQ_W'(pf.root);
    out_mag_nxt = pf.root + ROOT_W'(rnd_up);

    zsum = pf.z + Z_RND;
    zsh  = zsum >>> Z_SH;
    if (zsh > zacc_t'(PI_Q13)) begin
      ang_cordic = PI_Q13;
    end else if (zsh < -zacc_t'(PI_Q13)) begin
      ang_cordic = -PI_Q13;
    end else begin
      ang_cordic = zsh[15:0];
    end

    case (pf.spec)
      SPEC_NONE:  out_ang_nxt = ang_cordic;
      SPEC_ZERO:  out_ang_nxt = '0;
      SPEC_POS_Y: out_ang_nxt = HALF_PI_Q13;
      SPEC_NEG_Y: out_ang_nxt = -HALF_PI_Q13;
      SPEC_NEG_X: out_ang_nxt = PI_Q13;
      default:    out_ang_nxt = ang_cordic;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STG-1]) begin
      out_mag_r <= out_mag_nxt;
      out_ang_r <= out_ang_nxt;
    end
  end

  assign out_ch.magnitude = out_mag_r;
  assign out_ch.angle     = out_ang_r;

  // Occupancy now and after this cycle's transfers, and the angle range check.
  int   occ_now;
  int   occ_nxt;
  logic ang_in_range;

  assign occ_now      = $countones(v_r);
  assign occ_nxt      = occ_now + int'(in_xfer) - int'(out_xfer);
  assign ang_in_range = (out_ch.angle <= PI_Q13) && (out_ch.angle >= -PI_Q13);

  // Out of reset, input held off only when every stage holds an item.
  `CTP_ASSERT_IMP(a_full_when_blocked, !in_ch.ready, &v_r, "input blocked with a free stage")
  // Items in flight track the transfers on both sides.
  `CTP_ASSERT_IMP(a_occupancy, $past(rst_n), occ_now == $past(occ_nxt), "occupancy mismatch")
  // Clamped angle stays within [-pi, pi].
  `CTP_ASSERT_IMP(a_angle_range, out_ch.valid, ang_in_range, "angle out of range")
  // Rounded length never exceeds the largest possible norm.
  `CTP_ASSERT_IMP(a_mag_range, out_ch.valid, out_ch.magnitude <= MAG_MAX, "magnitude out of range")

endmodule
`default_nettype wire
